/* design/url_query_parameter_extract_defines.svh */
// Assertion macros for the file that carries checks.
// Every check is clocked on clk and switched off while arst_n is low.
`ifndef URL_QUERY_PARAMETER_EXTRACT_DEFINES_SVH
`define URL_QUERY_PARAMETER_EXTRACT_DEFINES_SVH

// The consequent must hold in the same cycle as the trigger.
`define UQPE_ASSERT_SAME(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define UQPE_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* design/uqpe_pkg.sv */
`timescale 1ns / 1ps

package uqpe_pkg;

	// Longest parameter name that can be searched.
	localparam int unsigned MAX_NAME_BYTES = 16;
	localparam int unsigned LEN_W          = 5;

	// Entries in the result queue; it must take two results behind one in flight.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Characters that steer the parse.
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_QM  = 8'h3F;

	// Configuration register indexes.
	localparam logic [1:0] REG_NAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_NAME_LOW    = 2'd1;
	localparam logic [1:0] REG_NAME_HIGH   = 2'd2;

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_MATCH,
		PH_SKIP,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef logic [MAX_NAME_BYTES-1:0][7:0] name_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       found;
		logic       final_report;
	} result_t;

	// Results produced by one path byte: count of 0, 1 or 2, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} step_out_t;

	// Byte expected at pattern position pos: the name bytes, then '='.
	function automatic logic [7:0] uqpe_expected(input logic [LEN_W-1:0] pos,
			input logic [LEN_W-1:0] len, input name_t name);
		logic [7:0] ch;
		if (pos >= len) begin
			ch = CH_EQ;
		end else begin
			ch = name[pos[LEN_W-2:0]];
		end
		return ch;
	endfunction

endpackage

/* design/uqpe_step.sv */
`timescale 1ns / 1ps

module uqpe_step import uqpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       path_byte,
	input  logic             end_of_path,
	input  logic [LEN_W-1:0] name_length,
	input  name_t            name,
	output step_out_t        step_out
);

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] pos_q, pos_d;
	logic             found_q, found_d;
	logic [LEN_W-1:0] eff_len;
	logic [7:0]       exp_byte;
	logic             emit_value;
	result_t          value_res;
	result_t          final_res;

	// Lengths above the name storage are clamped to it.
	assign eff_len  = (name_length > LEN_W'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES)
		: name_length;
	assign exp_byte = uqpe_expected(pos_q, eff_len, name);

	// Parse state update and result generation for one byte.
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		found_d    = found_q;
		emit_value = 1'b0;
		case (phase_q)
			PH_SEEK: begin
				if (path_byte == CH_QM) begin
					phase_d = PH_MATCH;
					pos_d   = '0;
				end
			end
			PH_MATCH: begin
				if (path_byte == exp_byte) begin
					if (pos_q >= eff_len) begin
						phase_d = PH_VALUE;
						found_d = 1'b1;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + LEN_W'(1);
					end
				end else if (path_byte == CH_AMP) begin
					pos_d = '0;
				end else begin
					phase_d = PH_SKIP;
					pos_d   = '0;
				end
			end
			PH_SKIP: begin
				if (path_byte == CH_AMP) begin
					phase_d = PH_MATCH;
					pos_d   = '0;
				end
			end
			PH_VALUE: begin
				if (path_byte == CH_AMP) begin
					phase_d = PH_DONE;
				end else begin
					emit_value = 1'b1;
				end
			end
			default: begin
			end
		endcase

		value_res = '{value_byte: path_byte, found: 1'b0, final_report: 1'b0};
		final_res = '{value_byte: 8'h00, found: found_d, final_report: 1'b1};

		// The last byte reports and returns the parse to its start.
		if (end_of_path) begin
			phase_d = PH_SEEK;
			pos_d   = '0;
			found_d = 1'b0;
		end

		step_out = '0;
		if (fire) begin
			if (emit_value) begin
				step_out.first  = value_res;
				step_out.second = final_res;
				step_out.count  = end_of_path ? 2'd2 : 2'd1;
			end else begin
				step_out.first = final_res;
				step_out.count = end_of_path ? 2'd1 : 2'd0;
			end
		end
	end

	// State registers advance only on a processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			found_q <= found_d;
		end
	end

endmodule

/* design/uqpe_out_queue.sv */
`timescale 1ns / 1ps

module uqpe_out_queue import uqpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_out_t push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   head
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	// Room for the two results that a single byte can produce.
	assign room      = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	// Storage writes of up to two results per cycle.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

/* design/url_query_parameter_extract.sv */
`timescale 1ns / 1ps
// Extracts the value of one query parameter from a request path that arrives one byte
// per beat. Bytes up to and including the first '?' are skipped; the configured name
// followed by '=' is then compared at the start of the query and after each '&', and
// the bytes of the first matching value come out one result per beat up to the next
// '&' or the end of the path. The beat carrying end_of_path also yields a final report
// (final_report high, found set if the name matched). The block takes one path byte
// per clock: a byte is captured in an input register and parsed from there, its
// results being registered in a four-entry result queue before they appear. The result
// side drains one result per clock while out_ready is high; input is held back only
// while that queue cannot take the two results a final byte may produce. Configuration
// is accepted in every cycle and should be written while no path is in progress.
`include "url_query_parameter_extract_defines.svh"

module url_query_parameter_extract import uqpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  path_byte,
	input  logic        end_of_path,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  value_byte,
	output logic        found,
	output logic        final_report
);

	logic [LEN_W-1:0] name_length_q;
	logic [63:0]      name_low_q;
	logic [63:0]      name_high_q;
	name_t            name;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eop_s1;
	logic             room;
	logic             fire;
	step_out_t        step_out;
	result_t          head;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_length_q <= '0;
			name_low_q    <= '0;
			name_high_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NAME_LENGTH: name_length_q <= cfg_data[LEN_W-1:0];
				REG_NAME_LOW:    name_low_q    <= cfg_data;
				REG_NAME_HIGH:   name_high_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end
	assign name = name_t'({name_high_q, name_low_q});

	// Input register: refilled whenever its byte is parsed in the same cycle.
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= path_byte;
			eop_s1  <= end_of_path;
		end
	end

	// Parser.
	uqpe_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.path_byte   (byte_s1),
		.end_of_path (eop_s1),
		.name_length (name_length_q),
		.name        (name),
		.step_out    (step_out)
	);

	// Result queue.
	uqpe_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step_out),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign value_byte   = head.value_byte;
	assign found        = head.found;
	assign final_report = head.final_report;

	// Checks.
	`UQPE_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, valid_s1,
		"accepted byte did not reach the input register")
	`UQPE_ASSERT_SAME(a_two_only_last, step_out.count == 2'd2, eop_s1 && fire,
		"two results from a byte that is not the last one")
	`UQPE_ASSERT_SAME(a_report_zero, out_valid && final_report, value_byte == 8'h00,
		"final report carries a non-zero value byte")
	`UQPE_ASSERT_SAME(a_value_not_found, out_valid && !final_report, !found,
		"value result has found set")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import uqpe_pkg::*;

	// Tracks the parse of each path and holds the value bytes and final reports still owed.
	class value_predictor;
		logic [4:0]  name_len;
		logic [63:0] name_low;
		logic [63:0] name_high;
		phase_t      phase;
		logic [4:0]  match_pos;
		logic        matched;
		result_t     awaited_results[$];
		int          mismatches;

		function new();
			name_len   = '0;
			name_low   = '0;
			name_high  = '0;
			phase      = PH_SEEK;
			match_pos  = '0;
			matched    = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				REG_NAME_LENGTH: name_len = data[4:0];
				REG_NAME_LOW:    name_low = data;
				REG_NAME_HIGH:   name_high = data;
				default: ;
			endcase
		endfunction

		// Character wanted at a position of the pattern: the name, then '='.
		function logic [7:0] pattern_char(logic [4:0] pos, logic [4:0] len);
			if (pos >= len) begin
				return CH_EQ;
			end
			if (pos < 5'd8) begin
				return name_low[int'(pos) * 8 +: 8];
			end
			return name_high[(int'(pos) - 8) * 8 +: 8];
		endfunction

		function void note_path_beat(logic [7:0] ch, logic last);
			logic [4:0] len;
			result_t    res;
			len = (name_len > MAX_NAME_BYTES) ? 5'(MAX_NAME_BYTES) : name_len;
			case (phase)
				PH_SEEK: begin
					if (ch == CH_QM) begin
						phase     = PH_MATCH;
						match_pos = '0;
					end
				end
				PH_MATCH: begin
					if (ch == pattern_char(match_pos, len)) begin
						if (match_pos >= len) begin
							phase     = PH_VALUE;
							matched   = 1'b1;
							match_pos = '0;
						end else begin
							match_pos = match_pos + 5'd1;
						end
					end else if (ch == CH_AMP) begin
						match_pos = '0;
					end else begin
						phase     = PH_SKIP;
						match_pos = '0;
					end
				end
				PH_SKIP: begin
					if (ch == CH_AMP) begin
						phase     = PH_MATCH;
						match_pos = '0;
					end
				end
				PH_VALUE: begin
					if (ch == CH_AMP) begin
						phase = PH_DONE;
					end else begin
						res.value_byte   = ch;
						res.found        = 1'b0;
						res.final_report = 1'b0;
						awaited_results.push_back(res);
					end
				end
				default: ;
			endcase
			// The last byte of a path always closes it with a report and clears the parse.
			if (last) begin
				res.value_byte   = 8'h00;
				res.found        = matched;
				res.final_report = 1'b1;
				awaited_results.push_back(res);
				phase     = PH_SEEK;
				match_pos = '0;
				matched   = 1'b0;
			end
		endfunction

		task report(string what);
			$display("ERROR at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic [7:0] got_byte, logic got_found, logic got_final);
			result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result byte %02h found %b final %b",
					got_byte, got_found, got_final));
				return;
			end
			want = awaited_results.pop_front();
			if (got_byte !== want.value_byte) begin
				report($sformatf("value_byte %02h, wanted %02h", got_byte, want.value_byte));
			end
			if (got_found !== want.found) begin
				report($sformatf("found %b, wanted %b", got_found, want.found));
			end
			if (got_final !== want.final_report) begin
				report($sformatf("final_report %b, wanted %b", got_final, want.final_report));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_NAME_LENGTH;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  path_byte = 8'h00;
	logic        end_of_path = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  value_byte;
	logic        found;
	logic        final_report;

	value_predictor       predictor;
	int                   send_idle_pct = 29;
	int                   recv_idle_pct = 46;
	int                   beat_count = 0;
	logic [7:0]           path_buf[$];
	logic [15:0][7:0]     gen_name;
	int                   gen_len = 0;

	url_query_parameter_extract dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.path_byte(path_byte),
		.end_of_path(end_of_path),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_byte(value_byte),
		.found(found),
		.final_report(final_report)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// The receiver stalls at random, at the rate of the current regime.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every beat on the three channels is seen here, with the values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				predictor.write_reg(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				predictor.note_path_beat(path_byte, end_of_path);
			end
			if (out_valid && out_ready) begin
				predictor.check_result(value_byte, found, final_report);
			end
		end
	end

	task write_register(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// One path byte; the sender may hold off first, and valid stays up after the beat.
	task send_path_beat(input logic [7:0] ch, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		path_byte   <= ch;
		end_of_path <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beat_count++;
	endtask

	task send_path();
		for (int i = 0; i < path_buf.size(); i++) begin
			send_path_beat(path_buf[i], i == path_buf.size() - 1);
		end
	endtask

	// Lets every owed result drain and then waits out the pipeline, so that the
	// registers may be rewritten. The first edge makes sure the last beat has been noted.
	task settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predictor.awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function void load_text(string s);
		path_buf.delete();
		for (int i = 0; i < s.len(); i++) begin
			path_buf.push_back(s[i]);
		end
	endfunction

	// Name characters lean on the steering characters so that odd names get exercised.
	function logic [7:0] name_char();
		case ($urandom_range(9))
			0: return CH_AMP;
			1: return CH_EQ;
			2: return CH_QM;
			3: return 8'($urandom_range(255));
			default: return 8'h61 + 8'($urandom_range(3));
		endcase
	endfunction

	function void add_value();
		logic [7:0] ch;
		repeat ($urandom_range(5)) begin
			case ($urandom_range(7))
				0: ch = 8'($urandom_range(255));
				1: ch = CH_QM;
				2: ch = CH_EQ;
				default: ch = 8'h30 + 8'($urandom_range(9));
			endcase
			path_buf.push_back(ch);
		end
	endfunction

	// A query segment: mostly the full pattern, else a near miss, plain text or noise.
	function void add_segment();
		int kind;
		int cut;
		kind = $urandom_range(9);
		if (kind <= 6) begin
			cut = (kind <= 4) ? gen_len : $urandom_range(gen_len);
			for (int i = 0; i < cut; i++) begin
				path_buf.push_back(gen_name[i]);
			end
			if (kind > 4) begin
				path_buf.push_back(name_char());
			end
			if (kind <= 4 || $urandom_range(1)) begin
				path_buf.push_back(CH_EQ);
			end
			add_value();
		end else if (kind <= 8) begin
			add_value();
		end else begin
			repeat ($urandom_range(1, 4)) path_buf.push_back(8'($urandom_range(255)));
		end
	endfunction

	function void build_random_path();
		int segs;
		path_buf.delete();
		repeat ($urandom_range(4)) begin
			path_buf.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h2F);
		end
		if ($urandom_range(9) != 0) begin
			path_buf.push_back(CH_QM);
		end
		segs = $urandom_range(1, 4);
		for (int i = 0; i < segs; i++) begin
			if (i > 0) begin
				path_buf.push_back(CH_AMP);
			end
			add_segment();
		end
		if ($urandom_range(7) == 0 || path_buf.size() == 0) begin
			path_buf.push_back(CH_AMP);
		end
	endfunction

	// Picks a fresh name and writes all three registers; the block must be idle.
	task configure_name(input int raw_len);
		logic [63:0] len_word;
		gen_len = (raw_len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : raw_len;
		for (int i = 0; i < MAX_NAME_BYTES; i++) begin
			gen_name[i] = (i < gen_len) ? name_char() : 8'($urandom_range(255));
		end
		len_word      = {$urandom, $urandom};
		len_word[4:0] = raw_len[4:0];
		write_register(REG_NAME_LENGTH, len_word);
		write_register(REG_NAME_LOW, gen_name[7:0]);
		write_register(REG_NAME_HIGH, gen_name[15:8]);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int target;
		int round_end;
		int raw_len;
		bit first_round;
		predictor = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed paths against the name "id".
		write_register(REG_NAME_LENGTH, 64'd2);
		write_register(REG_NAME_LOW, 64'h0000_0000_0000_6469);
		write_register(REG_NAME_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_valid <= 1'b0;
		// No question mark at all.
		load_text("ab");
		send_path();
		// A question mark as the only byte leaves an empty query.
		load_text("?");
		send_path();
		// The '=' on the last byte: found, with an empty value.
		load_text("?id=");
		send_path();
		// Ampersand breaks a compare; later '?' is a value byte; the rest is ignored.
		load_text("?i&id=?&q");
		send_path();
		// A value byte on the last beat comes out ahead of the report.
		load_text("?id=v");
		send_path();
		settle();

		// Empty name, so the pattern is just '='; value bytes at both extremes.
		write_register(REG_NAME_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
		write_register(REG_NAME_LOW, 64'h0);
		write_register(REG_NAME_HIGH, 64'h0);
		cfg_valid <= 1'b0;
		load_text("?=");
		path_buf.push_back(8'h00);
		path_buf.push_back(8'hFF);
		send_path();
		settle();

		// Random paths under three idling regimes, with a new name every so often.
		first_round = 1'b1;
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			target = beat_count + 270;
			while (beat_count < target) begin
				case ($urandom_range(7))
					0: raw_len = 0;
					1: raw_len = 1;
					2: raw_len = 16;
					3: raw_len = 31;
					4: raw_len = 17;
					default: raw_len = $urandom_range(2, 12);
				endcase
				// An oversized length comes first, so clamping is seen early.
				if (first_round) begin
					raw_len = 31;
				end
				first_round = 1'b0;
				configure_name(raw_len);
				round_end = beat_count + 90;
				while (beat_count < round_end && beat_count < target) begin
					build_random_path();
					send_path();
				end
				settle();
			end
		end

		if (predictor.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/uqpe_pkg.sv
design/uqpe_step.sv
design/uqpe_out_queue.sv
design/url_query_parameter_extract.sv
verif/testbench.sv
